FILE: sv/bvm_pkg.sv
`default_nettype none

package bvm_pkg;

  // samples per averaged batch (power of two, 1..16)
  localparam int SAMPLES      = 16;
  localparam int SAMPLE_SHIFT = $clog2(SAMPLES);

  localparam int ADC_W  = 10;
  localparam int V_W    = 14;
  localparam int SUM_W  = 14;
  localparam int CNT_W  = 4;
  localparam int CORR_W = 11;
  localparam int DB_W   = 8;
  localparam int PCT_W  = 7;
  localparam int PROD_W = ADC_W + V_W;

  localparam logic [V_W-1:0] V_MAX = '1;

  // depth of the internal queues
  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);
  localparam int QCW    = QAW + 1;

  // configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CORR_CHG  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CORR_DIS  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DEAD      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_FULL      = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_RECHARGE  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_DEADBAND  = 3'd7;

  // register reset values
  localparam logic [V_W-1:0]  RST_SCALE    = 14'd6600;
  localparam logic [V_W-1:0]  RST_DEAD     = 14'd3300;
  localparam logic [V_W-1:0]  RST_FULL     = 14'd4150;
  localparam logic [V_W-1:0]  RST_RECHARGE = 14'd4000;
  localparam logic [DB_W-1:0] RST_DEADBAND = 8'd20;

  typedef enum logic {
    OP_SAMPLE = 1'b0,
    OP_CHARGE = 1'b1
  } op_t;

  typedef struct packed {
    logic                     enable;
    logic [V_W-1:0]           scale_mv;
    logic signed [CORR_W-1:0] corr_chg;
    logic signed [CORR_W-1:0] corr_dis;
    logic [V_W-1:0]           dead_mv;
    logic [V_W-1:0]           full_mv;
    logic [V_W-1:0]           recharge_mv;
    logic [DB_W-1:0]          deadband_mv;
  } cfg_t;

  // work handed from front to back: a charging update or a finished batch mean
  typedef struct packed {
    op_t              op;
    logic             chg;
    logic [ADC_W-1:0] mean;
  } cmd_t;

  typedef struct packed {
    logic [V_W-1:0]   voltage_mv;
    logic             charging;
    logic             full_res;
    logic             report;
    logic             dead;
    logic             became_full;
    logic             became_not_full;
    logic [PCT_W-1:0] percent;
  } result_t;

endpackage

`default_nettype wire

FILE: sv/battery_voltage_monitor_top.sv
// Battery voltage monitor with full/recharge hysteresis.
// Input channel (push/full): an item is either an ADC sample or a charging-
// state update. Samples are summed while enable is set; every 16th one closes
// a batch whose truncated mean is scaled to mV, corrected for the charging
// state, clamped, filtered by the deadband and checked against the
// dead/full/recharge thresholds. Charging updates always give a result.
// Result channel (empty/pop): a 4-deep queue; the oldest result sits on the
// ports while empty is low.
// Config channel (cfg_valid/cfg_ready): cfg_ready is always high; write only
// while the block is idle.
// Path: an accepted item is written to the command queue, then passes the
// multiply stage and the divide stage, then the check writes the result
// queue. Throughput: one item per cycle while the result queue has room, set
// by the check stage that holds the monitor state.
// Reset: registers return to their defaults, the sample batch, voltage,
// charging and full flags clear, the first check reports unconditionally.
// When the receiver stalls, the result queue fills, the back pipeline holds,
// then the 4-deep command queue fills and full rises.
`default_nettype none

module battery_voltage_monitor_top (
  input  wire logic                            clk,
  input  wire logic                            rst,
  // input items
  input  wire logic                            push,
  output logic                                 full,
  input  wire logic                            operation,
  input  wire logic [bvm_pkg::ADC_W-1:0]       adc_sample,
  input  wire logic                            charging_in,
  // result items
  output logic                                 empty,
  input  wire logic                            pop,
  output logic [bvm_pkg::V_W-1:0]              voltage_mv,
  output logic                                 charging,
  output logic                                 full_res,
  output logic                                 report,
  output logic                                 dead,
  output logic                                 became_full,
  output logic                                 became_not_full,
  output logic [bvm_pkg::PCT_W-1:0]            percent,
  // configuration writes
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [bvm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [bvm_pkg::V_W-1:0]         cfg_data
);
  import bvm_pkg::*;

  cfg_t    cfg;
  cmd_t    front_cmd, queue_cmd;
  result_t back_res, head;
  logic    front_push, cmd_full, cmd_empty, cmd_pop;
  logic    res_push, out_room;

  // config registers; the port never stalls
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.enable      <= 1'b0;
      cfg.scale_mv    <= RST_SCALE;
      cfg.corr_chg    <= '0;
      cfg.corr_dis    <= '0;
      cfg.dead_mv     <= RST_DEAD;
      cfg.full_mv     <= RST_FULL;
      cfg.recharge_mv <= RST_RECHARGE;
      cfg.deadband_mv <= RST_DEADBAND;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_ENABLE:   cfg.enable      <= cfg_data[0];
        CFG_SCALE:    cfg.scale_mv    <= cfg_data;
        CFG_CORR_CHG: cfg.corr_chg    <= cfg_data[CORR_W-1:0];
        CFG_CORR_DIS: cfg.corr_dis    <= cfg_data[CORR_W-1:0];
        CFG_DEAD:     cfg.dead_mv     <= cfg_data;
        CFG_FULL:     cfg.full_mv     <= cfg_data;
        CFG_RECHARGE: cfg.recharge_mv <= cfg_data;
        CFG_DEADBAND: cfg.deadband_mv <= cfg_data[DB_W-1:0];
        default:      cfg.enable      <= cfg.enable;
      endcase
    end
  end

  // front: accept items, accumulate batches, forward work
  bvm_front u_front (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .operation   (operation),
    .adc_sample  (adc_sample),
    .charging_in (charging_in),
    .enable      (cfg.enable),
    .cmd_full    (cmd_full),
    .full        (full),
    .cmd_push    (front_push),
    .cmd         (front_cmd)
  );

  // decouples the front from a stalled back end
  bvm_cmd_queue u_cmd_queue (
    .clk     (clk),
    .rst     (rst),
    .wr      (front_push),
    .wr_data (front_cmd),
    .rd      (cmd_pop),
    .q_full  (cmd_full),
    .q_empty (cmd_empty),
    .rd_data (queue_cmd)
  );

  // back: scale, correct, filter and check
  bvm_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .cmd_valid (!cmd_empty),
    .cmd       (queue_cmd),
    .out_room  (out_room),
    .cmd_pop   (cmd_pop),
    .res_push  (res_push),
    .res       (back_res)
  );

  bvm_out_queue u_out_queue (
    .clk     (clk),
    .rst     (rst),
    .wr      (res_push),
    .wr_data (back_res),
    .rd      (pop),
    .room    (out_room),
    .q_empty (empty),
    .head    (head)
  );

  assign voltage_mv      = head.voltage_mv;
  assign charging        = head.charging;
  assign full_res        = head.full_res;
  assign report          = head.report;
  assign dead            = head.dead;
  assign became_full     = head.became_full;
  assign became_not_full = head.became_not_full;
  assign percent         = head.percent;

endmodule

`default_nettype wire

FILE: sv/bvm_front.sv
`default_nettype none

module bvm_front (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        push,
  input  wire logic                        operation,
  input  wire logic [bvm_pkg::ADC_W-1:0]   adc_sample,
  input  wire logic                        charging_in,
  input  wire logic                        enable,
  input  wire logic                        cmd_full,
  output logic                             full,
  output logic                             cmd_push,
  output bvm_pkg::cmd_t                    cmd
);
  import bvm_pkg::*;

  localparam logic [CNT_W-1:0] SAMPLE_LAST = CNT_W'(SAMPLES - 1);

  logic [SUM_W-1:0] sample_sum, sample_sum_next;
  logic [CNT_W-1:0] sample_count;
  logic             accept, is_sample, last;

  assign full      = cmd_full;
  assign accept    = push && !cmd_full;
  assign is_sample = (op_t'(operation) == OP_SAMPLE);
  assign last      = (sample_count == SAMPLE_LAST);

  assign sample_sum_next = sample_sum + {{(SUM_W-ADC_W){1'b0}}, adc_sample};

  // charging updates always go back; samples only on the batch's last one while enabled
  assign cmd_push = accept && (!is_sample || (enable && last));
  assign cmd.op   = op_t'(operation);
  assign cmd.chg  = charging_in;
  assign cmd.mean = ADC_W'(sample_sum_next >> SAMPLE_SHIFT);

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_sum   <= '0;
      sample_count <= '0;
    end else if (accept && is_sample && enable) begin
      if (last) begin
        sample_sum   <= '0;
        sample_count <= '0;
      end else begin
        sample_sum   <= sample_sum_next;
        sample_count <= sample_count + 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

FILE: sv/bvm_cmd_queue.sv
`default_nettype none

module bvm_cmd_queue (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          wr,
  input  wire bvm_pkg::cmd_t wr_data,
  input  wire logic          rd,
  output logic               q_full,
  output logic               q_empty,
  output bvm_pkg::cmd_t      rd_data
);
  import bvm_pkg::*;

  cmd_t           entries [QDEPTH];
  logic [QAW-1:0] wr_ptr, rd_ptr;
  logic [QCW-1:0] count;
  logic           do_wr, do_rd;

  assign q_full  = (count == QCW'(QDEPTH));
  assign q_empty = (count == '0);
  assign do_wr   = wr && !q_full;
  assign do_rd   = rd && !q_empty;
  assign rd_data = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) wr_ptr <= wr_ptr + 1'b1;
      if (do_rd) rd_ptr <= rd_ptr + 1'b1;
      case ({do_wr, do_rd})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) entries[wr_ptr] <= wr_data;
  end

endmodule

`default_nettype wire

FILE: sv/bvm_back.sv
`default_nettype none

module bvm_back (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire bvm_pkg::cfg_t    cfg,
  input  wire logic             cmd_valid,
  input  wire bvm_pkg::cmd_t    cmd,
  input  wire logic             out_room,
  output logic                  cmd_pop,
  output logic                  res_push,
  output bvm_pkg::result_t      res
);
  import bvm_pkg::*;

  function automatic logic [PCT_W-1:0] pct_of(input logic [V_W-1:0] v, input logic chg);
    logic [PCT_W-1:0] p;
    if (chg) begin
      if (v >= 14'd4150)      p = 7'd100;
      else if (v >= 14'd3900) p = 7'd66;
      else if (v >= 14'd3780) p = 7'd33;
      else                    p = 7'd0;
    end else begin
      if (v >= 14'd3900)      p = 7'd100;
      else if (v >= 14'd3750) p = 7'd66;
      else if (v >= 14'd3610) p = 7'd33;
      else                    p = 7'd0;
    end
    return p;
  endfunction

  // whole pipe moves together; it only waits on room in the result queue
  logic adv;
  assign adv     = out_room;
  assign cmd_pop = adv && cmd_valid;

  // stage 1: mean * scale
  logic              s1_valid;
  op_t               s1_op;
  logic              s1_chg;
  logic [PROD_W-1:0] s1_prod;

  // stage 2: divide by 1023
  logic              s2_valid;
  op_t               s2_op;
  logic              s2_chg;
  logic [V_W-1:0]    s2_scaled;

  // x / 1023 as x = 1023*q0 + r1, r1 = 1023*q1 + r2, r2 < 2*1023
  logic [V_W-1:0]    q0;
  logic [V_W:0]      r1;
  logic [4:0]        q1;
  logic [ADC_W:0]    r2;
  logic [V_W:0]      quot;

  assign q0   = s1_prod[PROD_W-1:ADC_W];
  assign r1   = {{(V_W+1-ADC_W){1'b0}}, s1_prod[ADC_W-1:0]} + {1'b0, q0};
  assign q1   = r1[V_W:ADC_W];
  assign r2   = {1'b0, r1[ADC_W-1:0]} + {{(ADC_W+1-5){1'b0}}, q1};
  assign quot = {1'b0, q0} + {{(V_W+1-5){1'b0}}, q1}
              + {{V_W{1'b0}}, (r2 >= 11'd1023)};

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_op     <= cmd.op;
      s1_chg    <= cmd.chg;
      s1_prod   <= {{V_W{1'b0}}, cmd.mean} * {{ADC_W{1'b0}}, cfg.scale_mv};
      s2_op     <= s1_op;
      s2_chg    <= s1_chg;
      s2_scaled <= quot[V_W-1:0];
    end
  end

  // stage 3: correction, deadband, hysteresis; owns all monitor state
  logic [V_W-1:0] stored_voltage, stored_voltage_next;
  logic           is_charging, is_charging_next;
  logic           is_full, is_full_next;
  logic           force_report, force_report_next;

  logic signed [CORR_W-1:0] corr;
  logic signed [V_W+1:0]    corrected;
  logic [V_W-1:0]           v_new, v_chk, delta;
  logic                     accepted, emit;
  logic                     rep, dead_f, bf, bnf;

  always_comb begin
    stored_voltage_next = stored_voltage;
    is_charging_next    = is_charging;
    is_full_next        = is_full;
    force_report_next   = force_report;
    emit   = 1'b0;
    rep    = 1'b0;
    dead_f = 1'b0;
    bf     = 1'b0;
    bnf    = 1'b0;
    v_chk  = stored_voltage;

    corr      = is_charging ? cfg.corr_chg : cfg.corr_dis;
    corrected = $signed({2'b00, s2_scaled}) + (V_W+2)'(corr);
    if (corrected[V_W+1])    v_new = '0;
    else if (corrected[V_W]) v_new = V_MAX;
    else                     v_new = corrected[V_W-1:0];
    delta    = (v_new >= stored_voltage) ? v_new - stored_voltage : stored_voltage - v_new;
    accepted = (delta >= {{(V_W-DB_W){1'b0}}, cfg.deadband_mv});

    if (s2_valid) begin
      if (s2_op == OP_CHARGE) begin
        emit             = 1'b1;
        rep              = 1'b1;
        is_charging_next = s2_chg;
        if (!s2_chg) is_full_next = 1'b0;
      end else if (accepted || stored_voltage == '0) begin
        emit = 1'b1;
        if (accepted) v_chk = v_new;
        stored_voltage_next = v_chk;
        dead_f = (v_chk < cfg.dead_mv);
        rep    = force_report || !is_full || !is_charging || (v_chk < cfg.recharge_mv);
        if (rep) force_report_next = 1'b0;
        bf  = (v_chk >= cfg.full_mv) && !is_full;
        bnf = (v_chk < cfg.full_mv) && is_full
              && (!is_charging || (v_chk < cfg.recharge_mv));
        if (bf)  is_full_next = 1'b1;
        if (bnf) is_full_next = 1'b0;
      end
    end
  end

  assign res_push            = adv && emit;
  assign res.voltage_mv      = stored_voltage_next;
  assign res.charging        = is_charging_next;
  assign res.full_res        = is_full_next;
  assign res.report          = rep;
  assign res.dead            = dead_f;
  assign res.became_full     = bf;
  assign res.became_not_full = bnf;
  assign res.percent         = pct_of(stored_voltage_next, is_charging_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid       <= 1'b0;
      s2_valid       <= 1'b0;
      stored_voltage <= '0;
      is_charging    <= 1'b0;
      is_full        <= 1'b0;
      force_report   <= 1'b1;
    end else if (adv) begin
      s1_valid       <= cmd_valid;
      s2_valid       <= s1_valid;
      stored_voltage <= stored_voltage_next;
      is_charging    <= is_charging_next;
      is_full        <= is_full_next;
      force_report   <= force_report_next;
    end
  end

endmodule

`default_nettype wire

FILE: sv/bvm_out_queue.sv
`default_nettype none

module bvm_out_queue (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             wr,
  input  wire bvm_pkg::result_t wr_data,
  input  wire logic             rd,
  output logic                  room,
  output logic                  q_empty,
  output bvm_pkg::result_t      head
);
  import bvm_pkg::*;

  result_t        entries [QDEPTH];
  logic [QAW-1:0] wr_ptr, rd_ptr;
  logic [QCW-1:0] count;
  logic           do_wr, do_rd;

  assign room    = (count != QCW'(QDEPTH));
  assign q_empty = (count == '0);
  assign do_wr   = wr && room;
  assign do_rd   = rd && !q_empty;
  assign head    = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) wr_ptr <= wr_ptr + 1'b1;
      if (do_rd) rd_ptr <= rd_ptr + 1'b1;
      case ({do_wr, do_rd})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) entries[wr_ptr] <= wr_data;
  end

endmodule

`default_nettype wire

FILE: sv/bvm_checker.sv
`default_nettype none

module bvm_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        empty,
  input wire logic        pop,
  input wire logic [13:0] voltage_mv,
  input wire logic        full_res,
  input wire logic        became_full,
  input wire logic        became_not_full,
  input wire logic [6:0]  percent
);

  // nothing to show right after reset
  a_empty_after_reset: assert property (@(posedge clk) $past(rst) |-> empty)
    else $error("result shown right after reset");

  a_pct_levels: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (percent == 7'd0 || percent == 7'd33 || percent == 7'd66 || percent == 7'd100))
    else $error("percent off its four levels");

  a_edge_excl: assert property (@(posedge clk) disable iff (rst)
    !empty |-> !(became_full && became_not_full))
    else $error("full flag both set and cleared");

  a_edge_flag: assert property (@(posedge clk) disable iff (rst)
    !empty && (became_full || became_not_full) |-> (full_res == became_full))
    else $error("full flag disagrees with its transition");

  a_head_hold: assert property (@(posedge clk) disable iff (rst)
    !empty && !pop |=> !empty && $stable(voltage_mv))
    else $error("stalled result changed");

endmodule

bind battery_voltage_monitor_top bvm_checker u_bvm_checker (
  .clk             (clk),
  .rst             (rst),
  .empty           (empty),
  .pop             (pop),
  .voltage_mv      (voltage_mv),
  .full_res        (full_res),
  .became_full     (became_full),
  .became_not_full (became_not_full),
  .percent         (percent)
);

`default_nettype wire

FILE: test/tb_battery_voltage_monitor_top.sv
`timescale 1ns / 100ps

module tb_battery_voltage_monitor_top;
  import bvm_pkg::*;

  localparam int RESET_CYCLES = 9;
  localparam int DRAIN_CYCLES = 12;    // lets the pipeline and any queued samples flush
  localparam int STALL_LIMIT = 3000;   // cycles with no handshake at all
  localparam int HOLD_CYCLES = 300;    // long receiver hold-off, fills both queues
  localparam int PHASE_ITEMS = 110;
  localparam int QUIET_ITEMS = 30;     // disabled phase, samples are dropped
  localparam int MIN_RESULTS = 60;
  localparam int CHARGE_PCT = 8;       // share of charging updates in random traffic
  localparam int FLAT_PCT = 15;        // share of batches with uniform noise samples
  localparam int ADC_MAX = (1 << ADC_W) - 1;
  localparam logic [ADC_W-1:0] ADC_TOP = '1;
  localparam logic [ADC_W-1:0] ADC_ZERO = '0;

  localparam int DIVISOR = 1023;   // full-scale converter code
  // percentage steps, charging and discharging curves
  localparam int CHG_TOP = 4150;
  localparam int CHG_MID = 3900;
  localparam int CHG_LOW = 3780;
  localparam int DIS_TOP = 3900;
  localparam int DIS_MID = 3750;
  localparam int DIS_LOW = 3610;

  // Mirrors the monitor state and holds the results still owed by the block.
  class monitor_scoreboard;
    localparam int REPORT_MAX = 10;
    localparam logic [PCT_W-1:0] PCT_FULL = 7'd100;
    localparam logic [PCT_W-1:0] PCT_TWO_THIRDS = 7'd66;
    localparam logic [PCT_W-1:0] PCT_ONE_THIRD = 7'd33;
    localparam logic [PCT_W-1:0] PCT_EMPTY = 7'd0;

    cfg_t             regs;
    logic [SUM_W-1:0] acc_sum;
    logic [CNT_W-1:0] acc_count;
    logic [V_W-1:0]   volt;
    bit               chg_state;
    bit               full_state;
    bit               report_pending;
    result_t          expected_q[$];
    int               mismatches;
    int               results_noted;

    function new();
      regs = '0;
      regs.scale_mv = RST_SCALE;
      regs.dead_mv = RST_DEAD;
      regs.full_mv = RST_FULL;
      regs.recharge_mv = RST_RECHARGE;
      regs.deadband_mv = RST_DEADBAND;
      acc_sum = '0;
      acc_count = '0;
      volt = '0;
      chg_state = 1'b0;
      full_state = 1'b0;
      report_pending = 1'b1;
      mismatches = 0;
      results_noted = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [V_W-1:0] data);
      case (idx)
        CFG_ENABLE:   regs.enable = data[0];
        CFG_SCALE:    regs.scale_mv = data;
        CFG_CORR_CHG: regs.corr_chg = data[CORR_W-1:0];
        CFG_CORR_DIS: regs.corr_dis = data[CORR_W-1:0];
        CFG_DEAD:     regs.dead_mv = data;
        CFG_FULL:     regs.full_mv = data;
        CFG_RECHARGE: regs.recharge_mv = data;
        CFG_DEADBAND: regs.deadband_mv = data[DB_W-1:0];
        default: ;
      endcase
    endfunction

    function logic [PCT_W-1:0] charge_level(logic [V_W-1:0] v, bit c);
      if (c) begin
        if (v >= CHG_TOP) return PCT_FULL;
        if (v >= CHG_MID) return PCT_TWO_THIRDS;
        if (v >= CHG_LOW) return PCT_ONE_THIRD;
        return PCT_EMPTY;
      end
      if (v >= DIS_TOP) return PCT_FULL;
      if (v >= DIS_MID) return PCT_TWO_THIRDS;
      if (v >= DIS_LOW) return PCT_ONE_THIRD;
      return PCT_EMPTY;
    endfunction

    function void queue_result(bit rep, bit is_dead, bit bf, bit bnf);
      result_t r;
      r.voltage_mv = volt;
      r.charging = chg_state;
      r.full_res = full_state;
      r.report = rep;
      r.dead = is_dead;
      r.became_full = bf;
      r.became_not_full = bnf;
      r.percent = charge_level(volt, chg_state);
      expected_q.push_back(r);
      results_noted++;
    endfunction

    function void note_item(op_t op, logic [ADC_W-1:0] adc, logic chg);
      int mean;
      int scaled;
      int corrected;
      int gap;
      logic [V_W-1:0] nv;
      bit rep;
      bit bf;
      bit bnf;
      if (op == OP_CHARGE) begin
        if (!chg) full_state = 1'b0;
        chg_state = chg;
        queue_result(1'b1, 1'b0, 1'b0, 1'b0);
        return;
      end
      if (!regs.enable) return;
      acc_sum = acc_sum + adc;
      if (int'(acc_count) + 1 < SAMPLES) begin
        acc_count = acc_count + 1'b1;
        return;
      end
      mean = int'(acc_sum) / SAMPLES;
      acc_sum = '0;
      acc_count = '0;
      scaled = mean * int'(regs.scale_mv) / DIVISOR;
      corrected = scaled + (chg_state ? int'($signed(regs.corr_chg))
                                      : int'($signed(regs.corr_dis)));
      if (corrected < 0) corrected = 0;
      if (corrected > int'(V_MAX)) corrected = int'(V_MAX);
      nv = corrected[V_W-1:0];
      gap = (nv >= volt) ? int'(nv - volt) : int'(volt - nv);
      // inside the deadband: silent, unless nothing has been stored yet
      if (gap >= int'(regs.deadband_mv)) volt = nv;
      else if (volt != '0) return;
      rep = report_pending || !full_state || !chg_state || (volt < regs.recharge_mv);
      if (rep) report_pending = 1'b0;
      bf = 1'b0;
      bnf = 1'b0;
      if (volt >= regs.full_mv && !full_state) begin
        full_state = 1'b1;
        bf = 1'b1;
      end
      if (volt < regs.full_mv && full_state && (!chg_state || volt < regs.recharge_mv)) begin
        full_state = 1'b0;
        bnf = 1'b1;
      end
      queue_result(rep, volt < regs.dead_mv, bf, bnf);
    endfunction

    function string show(result_t r);
      return $sformatf("mv=%0d chg=%0b full=%0b rep=%0b dead=%0b bf=%0b bnf=%0b pct=%0d",
                       r.voltage_mv, r.charging, r.full_res, r.report, r.dead,
                       r.became_full, r.became_not_full, r.percent);
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX) $display("unexpected result: %s", show(got));
        return;
      end
      want = expected_q.pop_front();
      if (got.voltage_mv !== want.voltage_mv || got.charging !== want.charging ||
          got.full_res !== want.full_res || got.report !== want.report ||
          got.dead !== want.dead || got.became_full !== want.became_full ||
          got.became_not_full !== want.became_not_full || got.percent !== want.percent) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("result mismatch\n  expected %s\n  actual   %s", show(want), show(got));
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic                 clk;
  logic                 rst;
  logic                 push;
  logic                 full;
  logic                 operation;
  logic [ADC_W-1:0]     adc_sample;
  logic                 charging_in;
  logic                 empty;
  logic                 pop;
  logic [V_W-1:0]       voltage_mv;
  logic                 charging;
  logic                 full_res;
  logic                 report;
  logic                 dead;
  logic                 became_full;
  logic                 became_not_full;
  logic [PCT_W-1:0]     percent;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [V_W-1:0]       cfg_data;

  monitor_scoreboard sb;
  result_t           popped;
  int                send_idle_pct;
  int                recv_idle_pct;
  int                hold_left;
  int                quiet_cycles;
  bit                hold_req;
  bit                input_stalled;

  battery_voltage_monitor_top DUT (.*);

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Result side: pop is redrawn every falling edge; a hold-off request from the
  // stimulus process is picked up at the rising edge and counted down here.
  initial begin
    pop = 1'b0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req = 1'b0;
      end
      @(negedge clk);
      if (hold_left > 0) begin
        pop <= 1'b0;
        hold_left--;
      end else begin
        pop <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Every popped item goes against the oldest prediction.
  always @(posedge clk) begin
    if (!rst && pop && !empty) begin
      popped = '{voltage_mv, charging, full_res, report, dead,
                 became_full, became_not_full, percent};
      sb.check_result(popped);
    end
  end

  // Watchdog: any handshake on any channel restarts the count.
  initial begin
    quiet_cycles = 0;
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || (push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("status: fail");
    $finish;
  end

  // One input item. push is left high on return so back-to-back items keep it
  // high; sender gaps drop it for whole cycles before the next item.
  task automatic send_item(op_t op, logic [ADC_W-1:0] adc, logic chg);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(negedge clk);
    end
    push <= 1'b1;
    operation <= op;
    adc_sample <= adc;
    charging_in <= chg;
    @(posedge clk);
    while (full) begin
      input_stalled = 1'b1;
      @(posedge clk);
    end
    sb.note_item(op, adc, chg);
    @(negedge clk);
  endtask

  // Stop sending, wait for every owed result, then let trailing samples that
  // make no result flush through the pipe.
  task automatic settle();
    push <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [V_W-1:0] data);
    cfg_index <= idx;
    cfg_data <= data;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.write_reg(idx, data);
    @(negedge clk);
  endtask

  // Writes the whole register set; only called with the block idle.
  task automatic apply_setting(cfg_t s);
    cfg_write(CFG_ENABLE, V_W'(s.enable));
    cfg_write(CFG_SCALE, s.scale_mv);
    cfg_write(CFG_CORR_CHG, V_W'(s.corr_chg));
    cfg_write(CFG_CORR_DIS, V_W'(s.corr_dis));
    cfg_write(CFG_DEAD, s.dead_mv);
    cfg_write(CFG_FULL, s.full_mv);
    cfg_write(CFG_RECHARGE, s.recharge_mv);
    cfg_write(CFG_DEADBAND, s.deadband_mv);
    cfg_valid <= 1'b0;
  endtask

  function automatic cfg_t make_setting(int en, int scale, int cc, int cd,
                                        int dead_lvl, int full_lvl, int rech, int db);
    cfg_t s;
    s.enable = en[0];
    s.scale_mv = scale[V_W-1:0];
    s.corr_chg = cc[CORR_W-1:0];
    s.corr_dis = cd[CORR_W-1:0];
    s.dead_mv = dead_lvl[V_W-1:0];
    s.full_mv = full_lvl[V_W-1:0];
    s.recharge_mv = rech[V_W-1:0];
    s.deadband_mv = db[DB_W-1:0];
    return s;
  endfunction

  // wide: any register values but a zero scale, enable set; otherwise a plausible single-cell pack
  function automatic cfg_t random_setting(bit wide);
    int full_lvl;
    if (wide)
      return make_setting(1, $urandom_range(1, 16383), $urandom_range(2047),
                          $urandom_range(2047), $urandom_range(16383),
                          $urandom_range(16383), $urandom_range(16383),
                          $urandom_range(255));
    full_lvl = $urandom_range(3900, 4300);
    return make_setting(1, $urandom_range(4000, 9000), int'($urandom_range(400)) - 200,
                        int'($urandom_range(400)) - 200, $urandom_range(2800, 3600),
                        full_lvl, full_lvl - int'($urandom_range(300)),
                        $urandom_range(40));
  endfunction

  function automatic int clip_adc(int v);
    if (v < 0) return 0;
    if (v > ADC_MAX) return ADC_MAX;
    return v;
  endfunction

  // Converter code whose voltage lands near one of the thresholds most of the
  // time, anywhere in range otherwise.
  function automatic int pick_base(cfg_t s);
    int marks[8];
    int target;
    marks = '{s.full_mv, s.recharge_mv, s.dead_mv, DIS_LOW,
              DIS_MID, CHG_LOW, CHG_MID, CHG_TOP};
    if ($urandom_range(9) < 6)
      target = marks[$urandom_range(7)] + int'($urandom_range(200)) - 100;
    else
      target = $urandom_range(16383);
    return clip_adc(target * DIVISOR / int'(s.scale_mv));
  endfunction

  // Mostly whole batches around a level (kept half the time, so the deadband
  // gets hit), some batches of pure noise, charging updates sprinkled in
  // anywhere, including mid-batch. A held phase keeps sending until the input
  // has been seen backed up.
  task automatic run_phase(cfg_t s, int n_items, int min_results, bit with_hold);
    int sent;
    int in_batch;
    int base;
    int spread;
    bit flat;
    settle();
    apply_setting(s);
    sent = 0;
    in_batch = 0;
    base = 0;
    spread = 0;
    flat = 1'b0;
    input_stalled = 1'b0;
    while (sent < n_items || sb.results_noted < min_results ||
           (with_hold && !input_stalled && sent < 3 * n_items)) begin
      if (with_hold && sent == n_items / 3) hold_req = 1'b1;
      if ($urandom_range(99) < CHARGE_PCT) begin
        send_item(OP_CHARGE, ADC_W'($urandom_range(ADC_MAX)), 1'($urandom_range(1)));
      end else begin
        if (in_batch == 0) begin
          flat = ($urandom_range(99) < FLAT_PCT);
          if ($urandom_range(1) == 0 || base == 0) base = pick_base(s);
          case ($urandom_range(3))
            0: spread = 0;
            1: spread = 1;
            2: spread = 4;
            default: spread = 24;
          endcase
        end
        send_item(OP_SAMPLE,
                  ADC_W'(flat ? int'($urandom_range(ADC_MAX))
                              : clip_adc(base + int'($urandom_range(2 * spread)) - spread)),
                  1'($urandom_range(1)));
        in_batch = (in_batch + 1) % SAMPLES;
      end
      sent++;
    end
  endtask

  initial begin
    int i;
    sb = new();
    rst = 1'b1;
    push = 1'b0;
    operation = OP_SAMPLE;
    adc_sample = '0;
    charging_in = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = CFG_ENABLE;
    cfg_data = '0;
    hold_req = 1'b0;
    input_stalled = 1'b0;
    send_idle_pct = 6;
    recv_idle_pct = 72;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Out of reset the monitor is off: samples vanish, charging updates still
    // report (clearing charge must also drop the full flag).
    send_item(OP_SAMPLE, ADC_TOP, 1'b0);
    send_item(OP_SAMPLE, ADC_ZERO, 1'b1);
    send_item(OP_CHARGE, ADC_W'($urandom_range(ADC_MAX)), 1'b1);
    send_item(OP_CHARGE, ADC_W'($urandom_range(ADC_MAX)), 1'b0);
    settle();
    apply_setting(make_setting(1, RST_SCALE, 0, 0, RST_DEAD, RST_FULL, RST_RECHARGE,
                               RST_DEADBAND));
    // One batch of alternating extremes: mean 511, just under the dead level,
    // first check reports unconditionally.
    for (i = 0; i < SAMPLES; i++)
      send_item(OP_SAMPLE, i[0] ? ADC_TOP : ADC_ZERO, i[1]);
    send_item(OP_CHARGE, ADC_W'($urandom_range(ADC_MAX)), 1'b1);

    // receiver mostly stalled
    run_phase(make_setting(1, 6600, 50, -30, 3300, 4150, 4000, 20), PHASE_ITEMS, 0, 1'b0);
    // top extremes: positive saturation, thresholds and deadband at maximum
    run_phase(make_setting(1, 16383, 1023, 1023, 16383, 16383, 16383, 255),
              PHASE_ITEMS, 0, 1'b0);

    // sender mostly idle
    send_idle_pct = 72;
    recv_idle_pct = 6;
    run_phase(random_setting(1'b0), PHASE_ITEMS, 0, 1'b0);
    // bottom extremes: voltage pinned at 0, zero deadband, zero thresholds
    run_phase(make_setting(1, 1, -1024, -1024, 0, 0, 0, 0), PHASE_ITEMS, 0, 1'b0);
    run_phase(make_setting(0, 6600, 0, 0, 3300, 4150, 4000, 20), QUIET_ITEMS, 0, 1'b0);

    // no idling; the last phase also holds the receiver off so input backs up
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_phase(random_setting(1'b1), PHASE_ITEMS, 0, 1'b0);
    run_phase(random_setting(1'b0), PHASE_ITEMS, MIN_RESULTS, 1'b1);

    settle();
    if (sb.mismatches == 0 && sb.pending() == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end
endmodule

FILE: sim.f
sv/bvm_pkg.sv
sv/bvm_front.sv
sv/bvm_cmd_queue.sv
sv/bvm_back.sv
sv/bvm_out_queue.sv
sv/battery_voltage_monitor_top.sv
sv/bvm_checker.sv
test/tb_battery_voltage_monitor_top.sv
